@@ src/lrc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the lidar return to Cartesian core.
// No dependencies; imported by the yaw, projection and top-level files.
package lrc_pkg;

    localparam int LASERS_PER_BLOCK          = 32;
    localparam int BEAM_COUNT                = 64;
    localparam int ROTATION_STEPS_PER_DEGREE = 100;
    localparam int BEAM_W                    = $clog2(BEAM_COUNT);

    // yaw angle reduction, all settled at elaboration
    localparam longint HALF_PI_Q29 = 843314857;
    localparam longint QUARTER     = 90 * ROTATION_STEPS_PER_DEGREE;
    localparam longint FULL_TURN   = 4 * QUARTER;
    localparam longint Z_INT       = HALF_PI_Q29 / QUARTER;
    localparam longint Z_FRAC      = HALF_PI_Q29 % QUARTER;
    localparam longint RECIP_Q32   = (64'sd1 <<< 32) / QUARTER;
    localparam longint CORDIC_GAIN = 652032871;

    localparam int CORDIC_STEPS = 16;
    localparam int YAW_LAT      = 6 + CORDIC_STEPS;   // turn register to trig output
    localparam int PROJ_LAT     = 4;

    localparam logic signed [31:0] ATAN_Q29 [CORDIC_STEPS] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510844,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384
    };

    // configuration register indexes
    localparam logic [3:0] CFG_MIN_DIST  = 4'd0;
    localparam logic [3:0] CFG_MAX_DIST  = 4'd1;
    localparam logic [3:0] CFG_BANK_CODE = 4'd2;
    localparam logic [3:0] CFG_APPLY_COR = 4'd3;

    localparam logic KIND_RETURN = 1'b0;

    localparam int ENTRY_W = 16 + 16 + 13;

    typedef struct packed {
        logic                valid;
        logic [BEAM_W-1:0]   beam;
        logic [15:0]         azimuth;
        logic signed [17:0]  corr_dist;
        logic signed [15:0]  cos_e;
        logic signed [15:0]  sin_e;
    } t_meta;

    // Q2.30 to Q1.15, round half up, saturate
    function automatic logic signed [16:0] to_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        begin
            t = (34'(v) + 34'sd16384) >>> 15;
            if (t > 34'sd32767)
                to_q15 = 17'sd32767;
            else if (t < -34'sd32768)
                to_q15 = -17'sd32768;
            else
                to_q15 = t[16:0];
        end
    endfunction

endpackage

@@ src/lrc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/lrc_yaw_trig.sv @@
`timescale 1ns / 1ps
// Pipelined yaw sine/cosine: quadrant split, constant scaling to radians, 16-step CORDIC.
// Depends on lrc_pkg.
module lrc_yaw_trig
    import lrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_turn,
    output logic signed [16:0] o_sin,
    output logic signed [16:0] o_cos
);
    logic [1:0]  r_q1, r_q2, r_q3, r_q4;
    logic [13:0] r_rem1;
    logic [30:0] r_a2, r_a3, r_a4;
    logic [25:0] r_v2, r_v3, r_v4;
    logic [12:0] r_qe3, r_qe4;
    logic [25:0] r_p4;
    logic signed [32:0] r_cx [CORDIC_STEPS+1];
    logic signed [32:0] r_cy [CORDIC_STEPS+1];
    logic signed [31:0] r_cz [CORDIC_STEPS+1];
    logic [1:0]         r_cq [CORDIC_STEPS+1];
    logic signed [16:0] r_sin, r_cos;

    logic [44:0] n_prod;
    logic [25:0] n_r;
    logic [12:0] n_q;
    logic signed [16:0] n_cs, n_sn;

    always_comb begin
        n_prod = 45'(r_v2) * 45'(RECIP_Q32);
        n_r    = r_v4 - r_p4;
        n_q    = (n_r >= 26'(QUARTER)) ? r_qe4 + 13'd1 : r_qe4;
        n_cs   = to_q15(r_cx[CORDIC_STEPS]);
        n_sn   = to_q15(r_cy[CORDIC_STEPS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quadrant and remainder
            if (i_turn >= 16'(3 * QUARTER)) begin
                r_q1 <= 2'd3; r_rem1 <= 14'(i_turn - 16'(3 * QUARTER));
            end else if (i_turn >= 16'(2 * QUARTER)) begin
                r_q1 <= 2'd2; r_rem1 <= 14'(i_turn - 16'(2 * QUARTER));
            end else if (i_turn >= 16'(QUARTER)) begin
                r_q1 <= 2'd1; r_rem1 <= 14'(i_turn - 16'(QUARTER));
            end else begin
                r_q1 <= 2'd0; r_rem1 <= 14'(i_turn);
            end
            // rem * HALF_PI / QUARTER = rem*Z_INT + floor(rem*Z_FRAC / QUARTER)
            r_q2  <= r_q1;
            r_a2  <= 31'(r_rem1) * 31'(Z_INT);
            r_v2  <= 26'(r_rem1) * 26'(Z_FRAC);
            r_q3  <= r_q2;
            r_a3  <= r_a2;
            r_v3  <= r_v2;
            r_qe3 <= n_prod[44:32];
            r_q4  <= r_q3;
            r_a4  <= r_a3;
            r_v4  <= r_v3;
            r_qe4 <= r_qe3;
            r_p4  <= 26'(r_qe3) * 26'(QUARTER);
            r_cq[0] <= r_q4;
            r_cx[0] <= 33'(CORDIC_GAIN);
            r_cy[0] <= '0;
            r_cz[0] <= 32'(r_a4 + 31'(n_q));
            // final rounding and quadrant mapping
            case (r_cq[CORDIC_STEPS])
                2'd0: begin r_sin <= n_sn;  r_cos <= n_cs;  end
                2'd1: begin r_sin <= n_cs;  r_cos <= -n_sn; end
                2'd2: begin r_sin <= -n_sn; r_cos <= -n_cs; end
                default: begin r_sin <= -n_cs; r_cos <= n_sn; end
            endcase
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cq[g+1] <= r_cq[g];
                if (r_cz[g] >= 0) begin
                    r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] - ATAN_Q29[g];
                end else begin
                    r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] + ATAN_Q29[g];
                end
            end
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

@@ src/lrc_project.sv @@
`timescale 1ns / 1ps
// Projection pipeline: elevation times yaw, times range, round and saturate.
// Depends on lrc_pkg; its last stage is the core's output register.
module lrc_project
    import lrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_meta              i_meta,
    input  logic signed [16:0] i_sin_y,
    input  logic signed [16:0] i_cos_y,
    output logic               o_valid,
    output logic [BEAM_W-1:0]  o_beam,
    output logic [15:0]        o_azimuth,
    output logic signed [17:0] o_dist,
    output logic signed [17:0] o_x,
    output logic signed [17:0] o_y,
    output logic signed [17:0] o_z
);
    t_meta              r_m1, r_m2, r_m3;
    logic signed [32:0] r_px1, r_py1;
    logic signed [33:0] r_pz1;
    logic signed [17:0] r_kx2, r_ky2, r_z2, r_z3;
    logic signed [35:0] r_mx3, r_my3;
    logic               r_valid;
    logic [BEAM_W-1:0]  r_beam;
    logic [15:0]        r_az;
    logic signed [17:0] r_dist, r_x, r_y, r_z;

    function automatic logic signed [17:0] sat18(input logic signed [36:0] v);
        logic signed [36:0] t;
        begin
            t = (v + 37'sd16384) >>> 15;
            if (t > 37'sd131071)       sat18 = 18'sd131071;
            else if (t < -37'sd131072) sat18 = -18'sd131072;
            else                       sat18 = t[17:0];
        end
    endfunction

    logic signed [33:0] n_kx, n_ky;
    always_comb begin
        n_kx = (34'(r_px1) + 34'sd16384) >>> 15;
        n_ky = (34'(r_py1) + 34'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.valid <= 1'b0;
            r_m2.valid <= 1'b0;
            r_m3.valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_en) begin
            r_m1  <= i_meta;
            r_px1 <= 33'(i_meta.cos_e) * 33'(i_sin_y);
            r_py1 <= 33'(i_meta.cos_e) * 33'(i_cos_y);
            r_pz1 <= 34'(i_meta.sin_e) * 34'(i_meta.corr_dist);
            r_m2  <= r_m1;
            r_kx2 <= n_kx[17:0];
            r_ky2 <= n_ky[17:0];
            r_z2  <= sat18(37'(r_pz1));
            r_m3  <= r_m2;
            r_mx3 <= 36'(r_kx2) * 36'(r_m2.corr_dist);
            r_my3 <= 36'(r_ky2) * 36'(r_m2.corr_dist);
            r_z3  <= r_z2;
            r_beam <= r_m3.beam;
            r_az   <= r_m3.azimuth;
            r_dist <= r_m3.corr_dist;
            r_x    <= sat18(37'(r_mx3));
            r_y    <= sat18(37'(r_my3));
            r_z    <= r_z3;
            r_valid <= r_m3.valid;
        end
    end

    assign o_valid   = r_valid;
    assign o_beam    = r_beam;
    assign o_azimuth = r_az;
    assign o_dist    = r_dist;
    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_z       = r_z;
endmodule

@@ src/lidar_return_to_cartesian_core.sv @@
`timescale 1ns / 1ps
// Top level: laser return to Cartesian point, with per-beam table in one RAM.
// Depends on lrc_pkg, lrc_ram, lrc_yaw_trig, lrc_project.
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------
// in       | sink      | i_in_valid/o_in_ready  | kind, header, rotation, range, table
// out      | source    | o_out_valid/i_out_ready| beam, azimuth, range, x, y, z
// cfg      | sink      | i_cfg_valid/o_cfg_ready| index, data
//
// One transaction per cycle while the output is not stalled; a kept return passes the
// entry stage, the yaw pipeline with its CORDIC chain and the projection stages.
// The whole pipeline advances together; it holds while the output register is full
// and not taken. Reset (synchronous, active low) clears stage valid bits and sets config
// registers to their defaults; the beam table RAM is not cleared. Table loads write the
// RAM at the accepting edge, so a return accepted the next cycle already sees the entry.
module lidar_return_to_cartesian_core
    import lrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [15:0]        i_header_code,
    input  logic [15:0]        i_rotation,
    input  logic [15:0]        i_raw_distance,
    input  logic [4:0]         i_slot,
    input  logic [5:0]         i_table_index,
    input  logic signed [15:0] i_table_cos,
    input  logic signed [15:0] i_table_sin,
    input  logic signed [12:0] i_table_offset,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_beam_index,
    output logic [15:0]        o_azimuth,
    output logic signed [17:0] o_corrected_distance,
    output logic signed [17:0] o_point_x,
    output logic signed [17:0] o_point_y,
    output logic signed [17:0] o_point_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    logic [15:0] r_min_dist, r_max_dist, r_bank_code;
    logic        r_apply_cor;

    logic              en;
    logic              accept;
    logic              n_keep;
    logic [BEAM_W-1:0] n_beam;

    logic              r_valid0;
    logic [BEAM_W-1:0] r_beam0;
    logic [15:0]       r_rot0, r_raw0, r_turn0;

    logic [ENTRY_W-1:0] ram_rdata;
    logic signed [12:0] rd_off;
    t_meta              n_meta1;
    t_meta              r_meta [YAW_LAT];
    logic signed [16:0] sin_y, cos_y;
    logic [BEAM_W-1:0]  out_beam;

    // advance everything whenever the output register can take a new value
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign accept      = i_in_valid && en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= 16'd0;
            r_max_dist  <= 16'd65535;
            r_bank_code <= 16'd56831;
            r_apply_cor <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_data;
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                CFG_BANK_CODE: r_bank_code <= i_cfg_data;
                CFG_APPLY_COR: r_apply_cor <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // beam index: slot, offset by one block when the header marks the lower bank
    always_comb begin
        n_beam = BEAM_W'((7'(i_slot) +
                 ((i_header_code == r_bank_code) ? 7'(LASERS_PER_BLOCK) : 7'd0)) % BEAM_COUNT);
        n_keep = (i_kind == KIND_RETURN) && (i_raw_distance >= r_min_dist) &&
                 (i_raw_distance <= r_max_dist);
    end

    // entry layout: cos, sin, offset
    lrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BEAM_COUNT)
    ) u_beam_table (
        .i_clk   (i_clk),
        .i_we    (accept && (i_kind != KIND_RETURN)),
        .i_waddr (BEAM_W'(i_table_index)),
        .i_wdata ({i_table_cos, i_table_sin, i_table_offset}),
        .i_re    (en),
        .i_raddr (n_beam),
        .o_rdata (ram_rdata)
    );

    // entry stage: filter, index, turn reduction
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_beam0 <= n_beam;
            r_rot0  <= i_rotation;
            r_raw0  <= i_raw_distance;
            r_turn0 <= (i_rotation >= 16'(FULL_TURN)) ? i_rotation - 16'(FULL_TURN)
                                                      : i_rotation;
        end
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (en) begin
            r_valid0 <= accept && n_keep;
        end
    end

    // table data lands with stage zero: apply the offset, start the metadata line
    assign rd_off = ram_rdata[12:0];
    always_comb begin
        n_meta1.valid     = r_valid0;
        n_meta1.beam      = r_beam0;
        n_meta1.azimuth   = r_rot0;
        n_meta1.corr_dist = 18'(r_raw0) + (r_apply_cor ? 18'(rd_off) : 18'sd0);
        n_meta1.cos_e     = ram_rdata[ENTRY_W-1 -: 16];
        n_meta1.sin_e     = ram_rdata[28:13];
    end

    // hold metadata alongside the yaw pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < YAW_LAT; k++) begin
                r_meta[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_meta[0] <= n_meta1;
            for (int k = 1; k < YAW_LAT; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    lrc_yaw_trig u_yaw (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_turn (r_turn0),
        .o_sin  (sin_y),
        .o_cos  (cos_y)
    );

    lrc_project u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_meta    (r_meta[YAW_LAT-1]),
        .i_sin_y   (sin_y),
        .i_cos_y   (cos_y),
        .o_valid   (o_out_valid),
        .o_beam    (out_beam),
        .o_azimuth (o_azimuth),
        .o_dist    (o_corrected_distance),
        .o_x       (o_point_x),
        .o_y       (o_point_y),
        .o_z       (o_point_z)
    );

    assign o_beam_index = 6'(out_beam);
endmodule

@@ src/lrc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the lidar return to Cartesian core, attached by bind.
// Depends on nothing but the core's ports.
module lrc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [17:0] o_point_x,
    input logic signed [17:0] o_point_z
);
    // output held while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_point_x) && $stable(o_point_z))
        else $error("result changed while stalled");

    // input side stalls only when a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without backpressure");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result right after reset");
endmodule

bind lidar_return_to_cartesian_core lrc_checker u_lrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_point_x   (o_point_x),
    .o_point_z   (o_point_z)
);
